>>> hdl/tmcw_pkg.sv
// Package for the text mode console writer.
// Holds the transfer payload types, function codes, character constants and APB map.
// Used by every module of the block; it depends on nothing else.
`timescale 1ns / 1ps

package tmcw_pkg;

    localparam int COLUMNS_DEF = 80;
    localparam int ROWS_DEF    = 25;

    localparam int CHAR_W = 8;
    localparam int ATTR_W = 8;
    localparam int POS_W  = 11;
    localparam int CUR_W  = 11;
    localparam int CELL_W = CHAR_W + ATTR_W;

    typedef enum logic [1:0] {
        FN_PUT   = 2'd0,
        FN_READ  = 2'd1,
        FN_SET   = 2'd2,
        FN_CLEAR = 2'd3
    } t_func;

    typedef struct packed {
        t_func              func;
        logic [CHAR_W-1:0]  character;
        logic [ATTR_W-1:0]  attribute;
        logic [POS_W-1:0]   position;
    } t_in_item;

    typedef struct packed {
        logic [CUR_W-1:0]   cursor;
        logic [CHAR_W-1:0]  cell_character;
        logic [ATTR_W-1:0]  cell_attribute;
    } t_out_item;

    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
    localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;
    localparam logic [CHAR_W-1:0] CH_NUL       = 8'h00;
    localparam logic [ATTR_W-1:0] BS_ATTR      = 8'h07;
    localparam logic [ATTR_W-1:0] RESET_ATTR   = 8'h0F;

    localparam int APB_AW = 2;
    localparam int APB_DW = 32;
    localparam logic [APB_AW-1:0] REG_BLANK_ATTR = 2'd0;

endpackage

>>> hdl/tmcw_screen_ram.sv
// Screen cell memory of the text mode console writer.
// One write port and one read port with registered read data; uses tmcw_pkg.
`timescale 1ns / 1ps

module tmcw_screen_ram #(
    parameter int DEPTH = tmcw_pkg::COLUMNS_DEF * tmcw_pkg::ROWS_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [AW-1:0]               i_waddr,
    input  logic [tmcw_pkg::CELL_W-1:0] i_wdata,
    input  logic [AW-1:0]               i_raddr,
    output logic [tmcw_pkg::CELL_W-1:0] o_rdata
);

    logic [tmcw_pkg::CELL_W-1:0] r_mem [DEPTH];
    logic [tmcw_pkg::CELL_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/tmcw_apb_regs.sv
// APB configuration register of the text mode console writer.
// Holds the blank attribute used by scroll and clear; uses tmcw_pkg.
`timescale 1ns / 1ps

module tmcw_apb_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [tmcw_pkg::APB_AW-1:0] paddr,
    input  logic [tmcw_pkg::APB_DW-1:0] pwdata,
    output logic [tmcw_pkg::APB_DW-1:0] prdata,
    output logic                        pready,
    output logic [tmcw_pkg::ATTR_W-1:0] o_blank_attr
);

    logic [tmcw_pkg::ATTR_W-1:0] r_blank_attr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blank_attr <= tmcw_pkg::RESET_ATTR;
        end else if (psel && penable && pwrite && paddr == tmcw_pkg::REG_BLANK_ATTR) begin
            r_blank_attr <= pwdata[tmcw_pkg::ATTR_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr == tmcw_pkg::REG_BLANK_ATTR) begin
            prdata[tmcw_pkg::ATTR_W-1:0] = r_blank_attr;
        end
    end

    assign pready       = 1'b1;
    assign o_blank_attr = r_blank_attr;

endmodule

>>> hdl/tmcw_ctrl.sv
// Sequencer of the text mode console writer.
// Tracks the cursor, runs the copy and fill sweeps over the screen memory and
// drives the transfer handshakes; uses tmcw_pkg and drives tmcw_screen_ram.
`timescale 1ns / 1ps

module tmcw_ctrl #(
    parameter int COLUMNS = tmcw_pkg::COLUMNS_DEF,
    parameter int ROWS    = tmcw_pkg::ROWS_DEF,
    parameter int AW      = $clog2(COLUMNS * ROWS)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  tmcw_pkg::t_in_item          i_in,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output tmcw_pkg::t_out_item         o_out,
    input  logic [tmcw_pkg::ATTR_W-1:0] i_blank_attr,
    output logic                        o_mem_we,
    output logic [AW-1:0]               o_mem_waddr,
    output logic [tmcw_pkg::CELL_W-1:0] o_mem_wdata,
    output logic [AW-1:0]               o_mem_raddr,
    input  logic [tmcw_pkg::CELL_W-1:0] i_mem_rdata
);

    localparam int CELLS = COLUMNS * ROWS;
    localparam int LAST  = CELLS - COLUMNS;
    localparam int CW    = $clog2(CELLS + 1);
    localparam int COLW  = $clog2(COLUMNS);
    localparam int POS_W = tmcw_pkg::POS_W;
    localparam int CUR_W = tmcw_pkg::CUR_W;
    localparam int XW    = (CW > POS_W) ? CW : POS_W;

    localparam logic [CW-1:0]   CELLS_C = CW'(CELLS);
    localparam logic [CW-1:0]   LAST_C  = CW'(LAST);
    localparam logic [CW-1:0]   COLS_C  = CW'(COLUMNS);
    localparam logic [COLW-1:0] COL_MAX = COLW'(COLUMNS - 1);
    localparam logic [XW-1:0]   CELLS_X = XW'(CELLS);

    typedef enum logic [8:0] {
        ST_INIT   = 9'b000000001,
        ST_IDLE   = 9'b000000010,
        ST_READ   = 9'b000000100,
        ST_SEEK   = 9'b000001000,
        ST_SCROLL = 9'b000010000,
        ST_SFILL  = 9'b000100000,
        ST_PUT    = 9'b001000000,
        ST_CLEAR  = 9'b010000000,
        ST_DONE   = 9'b100000000
    } t_state;

    t_state                      r_state, n_state;
    logic [CW-1:0]               r_cursor, n_cursor;
    logic [CW-1:0]               r_base, n_base;
    logic [COLW-1:0]             r_col, n_col;
    logic [CW-1:0]               r_idx, n_idx;
    logic [AW-1:0]               r_widx, n_widx;
    logic                        r_wvalid, n_wvalid;
    logic                        r_out_valid, n_out_valid;
    tmcw_pkg::t_out_item         r_out, n_out;
    logic [tmcw_pkg::CHAR_W-1:0] r_char, n_char;
    logic [tmcw_pkg::ATTR_W-1:0] r_attr, n_attr;
    logic [CW-1:0]               r_target, n_target;
    logic                        r_rd_ok, n_rd_ok;
    logic [tmcw_pkg::CHAR_W-1:0] r_res_char, n_res_char;
    logic [tmcw_pkg::ATTR_W-1:0] r_res_attr, n_res_attr;

    logic [XW-1:0] w_pos_x;
    logic [CW:0]   w_base_step;
    logic          w_in_range;

    assign w_pos_x     = XW'(i_in.position);
    assign w_base_step = {1'b0, r_base} + {1'b0, COLS_C};
    assign w_in_range  = r_cursor < CELLS_C;

    always_comb begin
        n_state     = r_state;
        n_cursor    = r_cursor;
        n_base      = r_base;
        n_col       = r_col;
        n_idx       = r_idx;
        n_widx      = r_widx;
        n_wvalid    = 1'b0;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        n_char      = r_char;
        n_attr      = r_attr;
        n_target    = r_target;
        n_rd_ok     = r_rd_ok;
        n_res_char  = r_res_char;
        n_res_attr  = r_res_attr;
        o_mem_we    = 1'b0;
        o_mem_waddr = AW'(r_cursor);
        o_mem_wdata = {r_attr, r_char};
        o_mem_raddr = AW'(i_in.position);

        unique case (r_state)
            ST_INIT, ST_CLEAR: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = AW'(r_idx);
                o_mem_wdata = {(r_state == ST_INIT) ? tmcw_pkg::RESET_ATTR : i_blank_attr,
                               tmcw_pkg::CH_NUL};
                n_idx       = r_idx + 1'b1;
                if (r_idx == CELLS_C - 1'b1) begin
                    n_cursor = '0;
                    n_base   = '0;
                    n_col    = '0;
                    n_state  = (r_state == ST_INIT) ? ST_IDLE : ST_DONE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_char     = i_in.character;
                    n_attr     = i_in.attribute;
                    n_rd_ok    = w_pos_x < CELLS_X;
                    n_res_char = '0;
                    n_res_attr = '0;
                    n_idx      = '0;
                    n_state    = ST_DONE;
                    unique case (i_in.func)
                        tmcw_pkg::FN_PUT: begin
                            if (i_in.character == tmcw_pkg::CH_NEWLINE) begin
                                if (r_base >= LAST_C) begin
                                    n_state = ST_SCROLL;
                                end else begin
                                    n_base   = CW'(w_base_step);
                                    n_cursor = CW'(w_base_step);
                                    n_col    = '0;
                                end
                            end else if (i_in.character == tmcw_pkg::CH_BACKSPACE) begin
                                if (w_in_range && r_col != '0) begin
                                    o_mem_we    = 1'b1;
                                    o_mem_waddr = AW'(r_cursor - 1'b1);
                                    o_mem_wdata = {tmcw_pkg::BS_ATTR, tmcw_pkg::CH_SPACE};
                                    n_cursor    = r_cursor - 1'b1;
                                    n_col       = r_col - 1'b1;
                                end
                            end else if (!w_in_range) begin
                                n_state = ST_SCROLL;
                            end else begin
                                o_mem_we    = 1'b1;
                                o_mem_waddr = AW'(r_cursor);
                                o_mem_wdata = {i_in.attribute, i_in.character};
                                n_cursor    = r_cursor + 1'b1;
                                if (r_col == COL_MAX) begin
                                    n_col  = '0;
                                    n_base = CW'(w_base_step);
                                end else begin
                                    n_col = r_col + 1'b1;
                                end
                            end
                        end
                        tmcw_pkg::FN_READ: begin
                            n_state = ST_READ;
                        end
                        tmcw_pkg::FN_SET: begin
                            n_target = (w_pos_x > CELLS_X) ? CELLS_C : CW'(w_pos_x);
                            n_base   = '0;
                            n_col    = '0;
                            n_state  = ST_SEEK;
                        end
                        tmcw_pkg::FN_CLEAR: begin
                            n_state = ST_CLEAR;
                        end
                    endcase
                end
            end
            ST_READ: begin
                if (r_rd_ok) begin
                    n_res_char = i_mem_rdata[tmcw_pkg::CHAR_W-1:0];
                    n_res_attr = i_mem_rdata[tmcw_pkg::CELL_W-1:tmcw_pkg::CHAR_W];
                end
                n_state = ST_DONE;
            end
            ST_SEEK: begin
                if ({1'b0, r_target} >= w_base_step) begin
                    n_base = CW'(w_base_step);
                end else begin
                    n_col    = COLW'(r_target - r_base);
                    n_cursor = r_target;
                    n_state  = ST_DONE;
                end
            end
            ST_SCROLL: begin
                o_mem_raddr = AW'(r_idx + COLS_C);
                n_wvalid    = 1'b1;
                n_widx      = AW'(r_idx);
                n_idx       = r_idx + 1'b1;
                if (r_idx == LAST_C - 1'b1) begin
                    n_state = ST_SFILL;
                end
            end
            ST_SFILL: begin
                if (!r_wvalid) begin
                    o_mem_we    = 1'b1;
                    o_mem_waddr = AW'(r_idx);
                    o_mem_wdata = {i_blank_attr, tmcw_pkg::CH_NUL};
                    n_idx       = r_idx + 1'b1;
                    if (r_idx == CELLS_C - 1'b1) begin
                        n_cursor = LAST_C;
                        n_base   = LAST_C;
                        n_col    = '0;
                        n_state  = (r_char == tmcw_pkg::CH_NEWLINE) ? ST_DONE : ST_PUT;
                    end
                end
            end
            ST_PUT: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = AW'(LAST_C);
                o_mem_wdata = {r_attr, r_char};
                n_cursor    = LAST_C + 1'b1;
                n_col       = COLW'(1);
                n_state     = ST_DONE;
            end
            ST_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out.cursor         = CUR_W'(r_cursor);
                    n_out.cell_character = r_res_char;
                    n_out.cell_attribute = r_res_attr;
                    n_out_valid          = 1'b1;
                    n_state              = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_INIT;
            end
        endcase

        // The copy write of the previous sweep step lands in the cycle after its read.
        if (r_wvalid) begin
            o_mem_we    = 1'b1;
            o_mem_waddr = r_widx;
            o_mem_wdata = i_mem_rdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_INIT;
            r_cursor    <= '0;
            r_base      <= '0;
            r_col       <= '0;
            r_idx       <= '0;
            r_wvalid    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cursor    <= n_cursor;
            r_base      <= n_base;
            r_col       <= n_col;
            r_idx       <= n_idx;
            r_wvalid    <= n_wvalid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_widx     <= n_widx;
        r_out      <= n_out;
        r_char     <= n_char;
        r_attr     <= n_attr;
        r_target   <= n_target;
        r_rd_ok    <= n_rd_ok;
        r_res_char <= n_res_char;
        r_res_attr <= n_res_attr;
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cursor <= CELLS_C)
        else $error("cursor beyond the past-end value");

    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_col <= COL_MAX)
        else $error("column beyond the last column");

    a_cursor_split: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> ({1'b0, r_cursor} == {1'b0, r_base} + (CW + 1)'(r_col)))
        else $error("cursor does not match row start plus column");

    a_copy_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wvalid |-> $past(r_state) == ST_SCROLL)
        else $error("copy write outside a scroll sweep");

endmodule

>>> hdl/text_mode_console_writer.sv
// Text mode console writer: screen of character and attribute cells with a cursor.
// Channels: input transfers carry func, character, attribute and position; each
// accepted item gives exactly one output transfer with the cursor after the item
// and, for a cell read, that cell's character and attribute (zero otherwise).
// Both channels use valid and ready; one item is processed at a time, and
// o_in_ready is high while the sequencer is idle, even if a result still waits.
// Processing: an ordinary character, a newline without scroll or a backspace goes
// straight to the result; a cell read first waits for the registered memory read;
// set cursor steps the row start once per cycle; clear, a newline that scrolls and
// a character that scrolls sweep the screen one cell per cycle through the single
// write port of the screen memory. The sequencer is idle again at the edge that
// raises output valid, so the next item may be accepted while that result waits.
// Reset: i_rst_n is synchronous and active low. After reset a clearing pass over
// all COLUMNS*ROWS cells fills the screen with character 0 and attribute 0x0F while
// o_in_ready stays low; APB writes are taken during that pass.
// A stalled receiver holds the finished result in the output register; the next
// item may be accepted and processed, and its result waits until the slot frees.
// The blank attribute register is at APB address 0; pready is always high.
`timescale 1ns / 1ps

module text_mode_console_writer #(
    parameter int COLUMNS = tmcw_pkg::COLUMNS_DEF,
    parameter int ROWS    = tmcw_pkg::ROWS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  tmcw_pkg::t_in_item          i_in,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output tmcw_pkg::t_out_item         o_out,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [tmcw_pkg::APB_AW-1:0] paddr,
    input  logic [tmcw_pkg::APB_DW-1:0] pwdata,
    output logic [tmcw_pkg::APB_DW-1:0] prdata,
    output logic                        pready
);

    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW    = $clog2(CELLS);

    logic [tmcw_pkg::ATTR_W-1:0] w_blank_attr;
    logic                        w_mem_we;
    logic [AW-1:0]               w_mem_waddr;
    logic [tmcw_pkg::CELL_W-1:0] w_mem_wdata;
    logic [AW-1:0]               w_mem_raddr;
    logic [tmcw_pkg::CELL_W-1:0] w_mem_rdata;

    tmcw_apb_regs u_regs (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .o_blank_attr (w_blank_attr)
    );

    tmcw_screen_ram #(
        .DEPTH (CELLS),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_mem_waddr),
        .i_wdata (w_mem_wdata),
        .i_raddr (w_mem_raddr),
        .o_rdata (w_mem_rdata)
    );

    tmcw_ctrl #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS),
        .AW      (AW)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in         (i_in),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out        (o_out),
        .i_blank_attr (w_blank_attr),
        .o_mem_we     (w_mem_we),
        .o_mem_waddr  (w_mem_waddr),
        .o_mem_wdata  (w_mem_wdata),
        .o_mem_raddr  (w_mem_raddr),
        .i_mem_rdata  (w_mem_rdata)
    );

endmodule

>>> bench/tmcw_checker.sv
// Checker for the text mode console writer: keeps its own copy of the screen,
// cursor and blank attribute, predicts one result per input transfer and compares.
// Depends on tmcw_pkg for the payload types, function codes and character constants.
`timescale 1ns / 1ps

module console_checker #(
    parameter int COLUMNS = tmcw_pkg::COLUMNS_DEF,
    parameter int ROWS    = tmcw_pkg::ROWS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        i_in_ready,
    input  tmcw_pkg::t_in_item          i_in,
    input  logic                        i_out_valid,
    input  logic                        i_out_ready,
    input  tmcw_pkg::t_out_item         i_out,
    input  logic                        i_psel,
    input  logic                        i_penable,
    input  logic                        i_pwrite,
    input  logic [tmcw_pkg::APB_AW-1:0] i_paddr,
    input  logic [tmcw_pkg::APB_DW-1:0] i_pwdata,
    input  logic                        i_pready,
    output int                          o_mismatches,
    output int                          o_pending,
    output int                          o_checked,
    output int                          o_scrolls
);

    localparam int CELLS  = COLUMNS * ROWS;
    localparam int CHAR_W = tmcw_pkg::CHAR_W;
    localparam int ATTR_W = tmcw_pkg::ATTR_W;
    localparam int CUR_W  = tmcw_pkg::CUR_W;

    logic [CHAR_W-1:0]   screen_char [CELLS];
    logic [ATTR_W-1:0]   screen_attr [CELLS];
    int unsigned         cursor_pos;
    logic [ATTR_W-1:0]   blank_attr;
    tmcw_pkg::t_out_item expected_results [$];

    initial begin
        o_mismatches = 0;
        o_pending    = 0;
        o_checked    = 0;
        o_scrolls    = 0;
    end

    function automatic void fill_screen(input logic [ATTR_W-1:0] attr);
        for (int i = 0; i < CELLS; i++) begin
            screen_char[i] = tmcw_pkg::CH_NUL;
            screen_attr[i] = attr;
        end
    endfunction

    function automatic void scroll_screen();
        for (int i = 0; i < CELLS - COLUMNS; i++) begin
            screen_char[i] = screen_char[i + COLUMNS];
            screen_attr[i] = screen_attr[i + COLUMNS];
        end
        for (int i = CELLS - COLUMNS; i < CELLS; i++) begin
            screen_char[i] = tmcw_pkg::CH_NUL;
            screen_attr[i] = blank_attr;
        end
        cursor_pos = CELLS - COLUMNS;
        o_scrolls++;
    endfunction

    function automatic tmcw_pkg::t_out_item console_step(input tmcw_pkg::t_in_item item);
        tmcw_pkg::t_out_item res;
        int unsigned         row;
        res = '0;
        case (item.func)
            tmcw_pkg::FN_PUT: begin
                if (item.character == tmcw_pkg::CH_NEWLINE) begin
                    row = cursor_pos / COLUMNS;
                    if (row >= ROWS - 1) begin
                        scroll_screen();
                    end else begin
                        cursor_pos = (row + 1) * COLUMNS;
                    end
                end else if (item.character == tmcw_pkg::CH_BACKSPACE) begin
                    if (cursor_pos < CELLS && cursor_pos % COLUMNS != 0) begin
                        cursor_pos--;
                        screen_char[cursor_pos] = tmcw_pkg::CH_SPACE;
                        screen_attr[cursor_pos] = tmcw_pkg::BS_ATTR;
                    end
                end else begin
                    if (cursor_pos >= CELLS) begin
                        scroll_screen();
                    end
                    screen_char[cursor_pos] = item.character;
                    screen_attr[cursor_pos] = item.attribute;
                    cursor_pos++;
                end
            end
            tmcw_pkg::FN_READ: begin
                if (item.position < CELLS) begin
                    res.cell_character = screen_char[item.position];
                    res.cell_attribute = screen_attr[item.position];
                end
            end
            tmcw_pkg::FN_SET: begin
                cursor_pos = (item.position > CELLS) ? CELLS : item.position;
            end
            default: begin
                fill_screen(blank_attr);
                cursor_pos = 0;
            end
        endcase
        res.cursor = cursor_pos[CUR_W-1:0];
        return res;
    endfunction

    always @(posedge i_clk) begin
        tmcw_pkg::t_out_item want;
        if (!i_rst_n) begin
            fill_screen(tmcw_pkg::RESET_ATTR);
            cursor_pos = 0;
            blank_attr = tmcw_pkg::RESET_ATTR;
            expected_results.delete();
        end else begin
            // The result leaving now always belongs to an older transfer, so pop first.
            if (i_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: result with nothing expected: cursor %0d char 0x%02h %s",
                             $time, i_out.cursor, i_out.cell_character,
                             $sformatf("attr 0x%02h", i_out.cell_attribute));
                    o_mismatches++;
                end else begin
                    want = expected_results.pop_front();
                    o_checked++;
                    if (i_out.cursor !== want.cursor) begin
                        $display("%0t: cursor mismatch: expected %0d, actual %0d",
                                 $time, want.cursor, i_out.cursor);
                        o_mismatches++;
                    end
                    if (i_out.cell_character !== want.cell_character) begin
                        $display("%0t: cell character mismatch: expected 0x%02h, actual 0x%02h",
                                 $time, want.cell_character, i_out.cell_character);
                        o_mismatches++;
                    end
                    if (i_out.cell_attribute !== want.cell_attribute) begin
                        $display("%0t: cell attribute mismatch: expected 0x%02h, actual 0x%02h",
                                 $time, want.cell_attribute, i_out.cell_attribute);
                        o_mismatches++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                expected_results.push_back(console_step(i_in));
            end
            if (i_psel && i_penable && i_pwrite && i_pready
                && i_paddr == tmcw_pkg::REG_BLANK_ATTR) begin
                blank_attr = i_pwdata[ATTR_W-1:0];
            end
        end
        o_pending = expected_results.size();
    end

endmodule

>>> bench/tb.sv
// Top of the text mode console writer testbench: clock, reset, stimulus and verdict.
// Drives directed and random console items with bursty input and a stalling receiver.
// Depends on tmcw_pkg, text_mode_console_writer and console_checker.
`timescale 1ns / 1ps

module tb;

    localparam int COLUMNS     = tmcw_pkg::COLUMNS_DEF;
    localparam int ROWS        = tmcw_pkg::ROWS_DEF;
    localparam int CELLS       = COLUMNS * ROWS;
    localparam int CHAR_W      = tmcw_pkg::CHAR_W;
    localparam int ATTR_W      = tmcw_pkg::ATTR_W;
    localparam int POS_W       = tmcw_pkg::POS_W;
    localparam int APB_AW      = tmcw_pkg::APB_AW;
    localparam int APB_DW      = tmcw_pkg::APB_DW;
    localparam int PHASE_ITEMS = 450;
    localparam int STALL_LIMIT = 20000;

    logic                i_clk;
    logic                i_rst_n;
    logic                in_valid;
    logic                in_ready;
    tmcw_pkg::t_in_item  in_item;
    logic                out_valid;
    logic                out_ready;
    tmcw_pkg::t_out_item out_item;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [APB_AW-1:0]   paddr;
    logic [APB_DW-1:0]   pwdata;
    logic [APB_DW-1:0]   prdata;
    logic                pready;
    int                  mismatches;
    int                  pending;
    int                  checked;
    int                  scrolls;
    int                  sent_items;
    int                  burst_left;
    int                  idle_cycles;
    logic [ATTR_W-1:0]   attr_settings [4];

    text_mode_console_writer #(.COLUMNS(COLUMNS), .ROWS(ROWS)) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_item),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    console_checker #(.COLUMNS(COLUMNS), .ROWS(ROWS)) checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in         (in_item),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out        (out_item),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_pready     (pready),
        .o_mismatches (mismatches),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_scrolls    (scrolls)
    );

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic tmcw_pkg::t_in_item make_item(input tmcw_pkg::t_func func,
                                                     input logic [CHAR_W-1:0] ch,
                                                     input logic [ATTR_W-1:0] attr,
                                                     input logic [POS_W-1:0] pos);
        tmcw_pkg::t_in_item item;
        item.func      = func;
        item.character = ch;
        item.attribute = attr;
        item.position  = pos;
        return item;
    endfunction

    // Mostly text with line breaks and corrections, plus reads, cursor moves and clears.
    function automatic tmcw_pkg::t_in_item pick_item();
        tmcw_pkg::t_in_item item;
        int                 roll;
        roll = $urandom_range(0, 99);
        item = make_item(tmcw_pkg::FN_PUT, CHAR_W'($urandom_range(0, 255)),
                         ATTR_W'($urandom_range(0, 255)), POS_W'($urandom_range(0, 2047)));
        if (roll < 55) begin
            item.func = tmcw_pkg::FN_PUT;
        end else if (roll < 62) begin
            item.character = tmcw_pkg::CH_NEWLINE;
        end else if (roll < 67) begin
            item.character = tmcw_pkg::CH_BACKSPACE;
        end else if (roll < 82) begin
            item.func = tmcw_pkg::FN_READ;
            if ($urandom_range(0, 3) != 0) begin
                item.position = POS_W'($urandom_range(0, CELLS - 1));
            end
        end else if (roll < 92) begin
            item.func = tmcw_pkg::FN_SET;
            if ($urandom_range(0, 3) == 0) begin
                item.position = POS_W'($urandom_range(CELLS - 2 * COLUMNS, 2047));
            end else begin
                item.position = POS_W'($urandom_range(0, CELLS - 1));
            end
        end else if (roll < 94) begin
            item.func = tmcw_pkg::FN_CLEAR;
        end else begin
            item.func = tmcw_pkg::t_func'($urandom_range(0, 3));
        end
        return item;
    endfunction

    task automatic idle_for(input int cycles);
        repeat (cycles) begin
            @(negedge i_clk);
            in_valid = 1'b0;
        end
    endtask

    task automatic send_item(input tmcw_pkg::t_in_item item);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            if ($urandom_range(0, 3) != 0) begin
                idle_for($urandom_range(1, 12));
            end
        end
        burst_left--;
        @(negedge i_clk);
        in_valid = 1'b1;
        in_item  = item;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
        sent_items++;
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        in_valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_blank_attr(input logic [ATTR_W-1:0] value);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = tmcw_pkg::REG_BLANK_ATTR;
        pwdata  = APB_DW'(value);
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // The receiver switches between free flow, light, moderate and heavy stalling.
    initial begin
        int mode;
        out_ready = 1'b0;
        forever begin
            mode = $urandom_range(0, 3);
            repeat ($urandom_range(20, 200)) begin
                @(negedge i_clk);
                case (mode)
                    0: out_ready = 1'b1;
                    1: out_ready = ($urandom_range(0, 7) != 0);
                    2: out_ready = ($urandom_range(0, 1) != 0);
                    default: out_ready = ($urandom_range(0, 15) == 0);
                endcase
            end
        end
    end

    initial begin
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (in_valid && in_ready) || (out_valid && out_ready)
                || (psel && penable && pready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
        $display("tb: failure");
        $finish;
    end

    initial begin
        tmcw_pkg::t_in_item directed [$];
        i_rst_n    = 1'b0;
        in_valid   = 1'b0;
        in_item    = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        sent_items = 0;
        burst_left = 0;
        attr_settings[0] = 8'hFF;
        attr_settings[1] = ATTR_W'($urandom_range(1, 254));
        attr_settings[2] = tmcw_pkg::RESET_ATTR;
        attr_settings[3] = ATTR_W'($urandom_range(1, 254));

        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;
        while (!in_ready) @(negedge i_clk);
        write_blank_attr(8'h00);

        directed.push_back(make_item(tmcw_pkg::FN_READ, 8'h00, 8'h00, 11'd0));
        directed.push_back(make_item(tmcw_pkg::FN_READ, 8'hFF, 8'hFF, 11'd2047));
        directed.push_back(make_item(tmcw_pkg::FN_READ, 8'h00, 8'h00, 11'(CELLS)));
        directed.push_back(make_item(tmcw_pkg::FN_READ, 8'h00, 8'h00, 11'(CELLS - 1)));
        directed.push_back(make_item(tmcw_pkg::FN_SET, 8'h00, 8'h00, 11'd2047));
        directed.push_back(make_item(tmcw_pkg::FN_PUT, tmcw_pkg::CH_BACKSPACE, 8'h00, 11'd0));
        directed.push_back(make_item(tmcw_pkg::FN_PUT, 8'h41, 8'hFF, 11'd0));
        directed.push_back(make_item(tmcw_pkg::FN_READ, 8'h00, 8'h00, 11'(CELLS - COLUMNS)));
        directed.push_back(make_item(tmcw_pkg::FN_READ, 8'h00, 8'h00,
                                     11'(CELLS - COLUMNS + 1)));
        directed.push_back(make_item(tmcw_pkg::FN_PUT, tmcw_pkg::CH_BACKSPACE, 8'h00, 11'd0));
        directed.push_back(make_item(tmcw_pkg::FN_PUT, tmcw_pkg::CH_BACKSPACE, 8'h00, 11'd0));
        directed.push_back(make_item(tmcw_pkg::FN_READ, 8'h00, 8'h00, 11'(CELLS - COLUMNS)));
        directed.push_back(make_item(tmcw_pkg::FN_SET, 8'h00, 8'h00, 11'(CELLS / 2)));
        directed.push_back(make_item(tmcw_pkg::FN_PUT, tmcw_pkg::CH_NEWLINE, 8'h00, 11'd0));
        directed.push_back(make_item(tmcw_pkg::FN_PUT, 8'hFF, 8'h00, 11'd0));
        directed.push_back(make_item(tmcw_pkg::FN_PUT, tmcw_pkg::CH_NUL, 8'hFF, 11'd0));
        directed.push_back(make_item(tmcw_pkg::FN_SET, 8'h00, 8'h00, 11'(CELLS - 1)));
        directed.push_back(make_item(tmcw_pkg::FN_PUT, 8'h7E, 8'h5A, 11'd0));
        directed.push_back(make_item(tmcw_pkg::FN_PUT, tmcw_pkg::CH_NEWLINE, 8'h00, 11'd0));
        directed.push_back(make_item(tmcw_pkg::FN_PUT, tmcw_pkg::CH_NEWLINE, 8'h00, 11'd0));
        directed.push_back(make_item(tmcw_pkg::FN_SET, 8'h00, 8'h00,
                                     11'(CELLS - COLUMNS - 20)));
        directed.push_back(make_item(tmcw_pkg::FN_PUT, tmcw_pkg::CH_NEWLINE, 8'h00, 11'd0));
        directed.push_back(make_item(tmcw_pkg::FN_CLEAR, 8'h00, 8'h00, 11'd0));
        directed.push_back(make_item(tmcw_pkg::FN_READ, 8'h00, 8'h00, 11'(CELLS - 1)));
        directed.push_back(make_item(tmcw_pkg::FN_SET, 8'h00, 8'h00, 11'(CELLS)));
        foreach (directed[i]) begin
            send_item(directed[i]);
        end

        for (int phase = 0; phase < 4; phase++) begin
            wait_idle();
            write_blank_attr(attr_settings[phase]);
            repeat (PHASE_ITEMS) begin
                send_item(pick_item());
            end
        end

        wait_idle();
        repeat (CELLS + 8) @(negedge i_clk);

        $display("Sent %0d console items, checked %0d results, predicted %0d scrolls.",
                 sent_items, checked, scrolls);
        $display("Blank attribute went through 0x00, 0x%02h, 0x%02h, 0x%02h and 0x%02h.",
                 attr_settings[0], attr_settings[1], attr_settings[2], attr_settings[3]);
        if (mismatches == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
